>>> rtl/core/sbpp_pkg.sv
// sbpp_pkg: shared types, codes and spiral coordinate tables for the
// spiral bit pattern placer. No dependencies.
`timescale 1ns / 1ps

package sbpp_pkg;

	// cells on the spiral walk, one per index bit
	localparam int SPIRAL_LEN = 64;

	// spiral coordinates fit in -3..4
	typedef logic signed [3:0] coord_t;
	typedef coord_t coord_tab_t [SPIRAL_LEN];

	// input command codes
	typedef enum logic [1:0] {
		CMD_GEN_INDEX    = 2'd0,
		CMD_GEN_COUNTER  = 2'd1,
		CMD_LOAD_COUNTER = 2'd2
	} cmd_code_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_BITS_IN_USE = 2'd0,
		CFG_PAD         = 2'd1
	} cfg_reg_t;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT,
		ST_EMPTY
	} ctrl_state_t;

	// controller to datapath
	typedef struct packed {
		logic in_take;
		logic scan_step;
		logic pos_clr;
		logic pos_inc;
		logic emit_load;
		logic empty_load;
	} sbpp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic gen;
		logic scan_done;
		logic any;
		logic bit_set;
		logic is_last;
		logic out_free;
	} sbpp_stat_t;

	// walk right, turn left, segment lengths 1,1,2,2,3,3,...
	function automatic coord_tab_t spiral_tab(input logic want_y);
		coord_tab_t tab;
		int x;
		int y;
		int dx;
		int dy;
		int t;
		int seg_len;
		int turn_cnt;
		int steps;
		x = 0;
		y = 0;
		dx = 1;
		dy = 0;
		seg_len = 1;
		turn_cnt = 0;
		steps = 0;
		for (int k = 0; k < SPIRAL_LEN; k++) begin
			if (k > 0) begin
				x = x + dx;
				y = y + dy;
				steps = steps + 1;
				if (steps == seg_len) begin
					t = -dy;
					steps = 0;
					dy = dx;
					dx = t;
					turn_cnt = turn_cnt + 1;
					if (turn_cnt == 2) begin
						turn_cnt = 0;
						seg_len = seg_len + 1;
					end
				end
			end
			tab[k] = want_y ? coord_t'(y) : coord_t'(x);
		end
		return tab;
	endfunction

	localparam coord_tab_t SPIRAL_X = spiral_tab(1'b0);
	localparam coord_tab_t SPIRAL_Y = spiral_tab(1'b1);

endpackage

>>> rtl/core/spiral_bit_pattern_placer_unit.sv
// spiral_bit_pattern_placer_unit: top level with configuration registers,
// controller and datapath. Depends on sbpp_pkg, sbpp_ctrl, sbpp_dpath.
//
// channel   direction  handshake               payload
// item      in         item_valid/item_stall   command, index_value
// result    out        result_valid/result_stall  grid_width .. last
// cfg       in         cfg_valid/cfg_ready     cfg_index, cfg_data
//
// a counter load or an unused command is accepted in the idle state without a scan
// a generate first scans the used bits for the box, then walks up to the highest
// set bit and loads one beat per set bit (empty pattern: one beat); the single bit
// walker over the spiral tables serves both the scan and the walk
// a stalled result holds the walker at the next set bit; the last beat may wait
// in the result register while the next item is accepted
// arst_n clears the controller, counter, walker and result valid; config resets to
// bits_in_use 64, pad 0
`timescale 1ns / 1ps

module spiral_bit_pattern_placer_unit
	import sbpp_pkg::*;
#(
	parameter int MAX_BITS  = 64,
	parameter int PAD_LIMIT = 15
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  logic [1:0]        command,
	input  logic [63:0]       index_value,
	output logic              result_valid,
	input  logic              result_stall,
	output logic [5:0]        grid_width,
	output logic [5:0]        grid_height,
	output logic signed [5:0] origin_x,
	output logic signed [5:0] origin_y,
	output logic              has_cell,
	output logic [4:0]        cell_col,
	output logic [4:0]        cell_row,
	output logic              last,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [6:0]        cfg_data
);

	logic [6:0] bits_in_use_q;
	logic [3:0] pad_q;
	logic [6:0] nbits;
	logic [3:0] pad_eff;
	sbpp_cmd_t  cmd;
	sbpp_stat_t stat;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_in_use_q <= 7'd64;
			pad_q         <= 4'd0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_BITS_IN_USE: bits_in_use_q <= cfg_data;
				CFG_PAD:         pad_q         <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	// clamp to the build limits
	always_comb begin
		nbits   = (bits_in_use_q > 7'(MAX_BITS)) ? 7'(MAX_BITS) : bits_in_use_q;
		pad_eff = ({2'b00, pad_q} > 6'(PAD_LIMIT)) ? 4'(PAD_LIMIT) : pad_q;
	end

	sbpp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.stat       (stat),
		.cmd        (cmd)
	);

	sbpp_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.nbits        (nbits),
		.pad_eff      (pad_eff),
		.command      (command),
		.index_value  (index_value),
		.cmd          (cmd),
		.stat         (stat),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.grid_width   (grid_width),
		.grid_height  (grid_height),
		.origin_x     (origin_x),
		.origin_y     (origin_y),
		.has_cell     (has_cell),
		.cell_col     (cell_col),
		.cell_row     (cell_row),
		.last         (last)
	);

endmodule

>>> rtl/core/sbpp_ctrl.sv
// sbpp_ctrl: sequencing state machine for the placer (accept, box scan,
// cell emit). Depends on sbpp_pkg.
`timescale 1ns / 1ps

module sbpp_ctrl
	import sbpp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  sbpp_stat_t stat,
	output sbpp_cmd_t  cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					cmd.in_take = 1'b1;
					if (stat.gen) begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (stat.scan_done) begin
					cmd.pos_clr = 1'b1;
					state_d     = stat.any ? ST_EMIT : ST_EMPTY;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			ST_EMIT: begin
				if (stat.bit_set) begin
					if (stat.out_free) begin
						cmd.emit_load = 1'b1;
						if (stat.is_last) begin
							cmd.pos_clr = 1'b1;
							state_d     = ST_IDLE;
						end else begin
							cmd.pos_inc = 1'b1;
						end
					end
				end else begin
					cmd.pos_inc = 1'b1;
				end
			end
			ST_EMPTY: begin
				if (stat.out_free) begin
					cmd.empty_load = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/core/sbpp_dpath.sv
// sbpp_dpath: pattern and counter registers, bit walker over the spiral
// tables, bounding box and the result register. Depends on sbpp_pkg.
`timescale 1ns / 1ps

module sbpp_dpath
	import sbpp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [6:0]        nbits,
	input  logic [3:0]        pad_eff,
	input  logic [1:0]        command,
	input  logic [63:0]       index_value,
	input  sbpp_cmd_t         cmd,
	output sbpp_stat_t        stat,
	output logic              result_valid,
	input  logic              result_stall,
	output logic [5:0]        grid_width,
	output logic [5:0]        grid_height,
	output logic signed [5:0] origin_x,
	output logic signed [5:0] origin_y,
	output logic              has_cell,
	output logic [4:0]        cell_col,
	output logic [4:0]        cell_row,
	output logic              last
);

	logic [63:0] mask;
	logic [63:0] counter_q;
	logic [63:0] pattern_q;
	logic [6:0]  pos_q;
	logic [5:0]  pos_idx;
	logic [5:0]  last_set_q;
	logic        any_q;
	coord_t      minx_q;
	coord_t      maxx_q;
	coord_t      miny_q;
	coord_t      maxy_q;
	coord_t      cur_x;
	coord_t      cur_y;
	logic        cur_bit;
	logic        out_valid_q;

	assign mask    = ~(64'hFFFF_FFFF_FFFF_FFFF << nbits);
	assign pos_idx = pos_q[5:0];
	assign cur_x   = SPIRAL_X[pos_idx];
	assign cur_y   = SPIRAL_Y[pos_idx];
	assign cur_bit = pattern_q[pos_idx];

	// status toward the controller
	always_comb begin
		stat.gen       = (command == CMD_GEN_INDEX) || (command == CMD_GEN_COUNTER);
		stat.scan_done = (pos_q == nbits);
		stat.any       = any_q;
		stat.bit_set   = cur_bit;
		stat.is_last   = (pos_idx == last_set_q);
		stat.out_free  = !out_valid_q || !result_stall;
	end

	// counter, control side
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q <= '0;
		end else if (cmd.in_take) begin
			case (command)
				CMD_GEN_COUNTER:  counter_q <= (counter_q + 64'd1) & mask;
				CMD_LOAD_COUNTER: counter_q <= index_value & mask;
				default:          counter_q <= counter_q;
			endcase
		end
	end

	// working pattern, written before every scan
	always_ff @(posedge clk) begin
		if (cmd.in_take) begin
			case (command)
				CMD_GEN_INDEX:   pattern_q <= index_value & mask;
				CMD_GEN_COUNTER: pattern_q <= counter_q & mask;
				default:         pattern_q <= pattern_q;
			endcase
		end
	end

	// bit walker position and live flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			any_q <= 1'b0;
		end else begin
			if (cmd.in_take || cmd.pos_clr) begin
				pos_q <= '0;
			end else if (cmd.scan_step || cmd.pos_inc) begin
				pos_q <= pos_q + 7'd1;
			end
			if (cmd.in_take) begin
				any_q <= 1'b0;
			end else if (cmd.scan_step && cur_bit) begin
				any_q <= 1'b1;
			end
		end
	end

	// bounding box of the set cells and highest set bit
	always_ff @(posedge clk) begin
		if (cmd.scan_step && cur_bit) begin
			last_set_q <= pos_idx;
			if (!any_q || cur_x < minx_q) minx_q <= cur_x;
			if (!any_q || cur_x > maxx_q) maxx_q <= cur_x;
			if (!any_q || cur_y < miny_q) miny_q <= cur_y;
			if (!any_q || cur_y > maxy_q) maxy_q <= cur_y;
		end
	end

	// result fields for the current cell
	logic [6:0] pad2;
	logic [5:0] gw_cell;
	logic [5:0] gh_cell;
	logic [5:0] ox_cell;
	logic [5:0] oy_cell;
	logic [4:0] col_cell;
	logic [4:0] row_cell;
	logic [5:0] side_empty;
	logic [5:0] org_empty;

	always_comb begin
		pad2       = {2'b00, pad_eff, 1'b0};
		gw_cell    = 6'({{3{maxx_q[3]}}, maxx_q} - {{3{minx_q[3]}}, minx_q} + 7'd1 + pad2);
		gh_cell    = 6'({{3{maxy_q[3]}}, maxy_q} - {{3{miny_q[3]}}, miny_q} + 7'd1 + pad2);
		ox_cell    = {{2{minx_q[3]}}, minx_q} - {2'b00, pad_eff};
		oy_cell    = {{2{miny_q[3]}}, miny_q} - {2'b00, pad_eff};
		col_cell   = {cur_x[3], cur_x} - {minx_q[3], minx_q} + {1'b0, pad_eff};
		row_cell   = {cur_y[3], cur_y} - {miny_q[3], miny_q} + {1'b0, pad_eff};
		side_empty = 6'(pad2 + 7'd1);
		org_empty  = 6'd0 - {2'b00, pad_eff};
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_load || cmd.empty_load) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (cmd.emit_load) begin
			grid_width  <= gw_cell;
			grid_height <= gh_cell;
			origin_x    <= ox_cell;
			origin_y    <= oy_cell;
			has_cell    <= 1'b1;
			cell_col    <= col_cell;
			cell_row    <= row_cell;
			last        <= stat.is_last;
		end else if (cmd.empty_load) begin
			grid_width  <= side_empty;
			grid_height <= side_empty;
			origin_x    <= org_empty;
			origin_y    <= org_empty;
			has_cell    <= 1'b0;
			cell_col    <= '0;
			cell_row    <= '0;
			last        <= 1'b1;
		end
	end

	assign result_valid = out_valid_q;

	// a cell beat only comes from a set bit of the walk
	a_emit_on_set_bit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_load |-> (cur_bit && any_q && (pos_q < nbits)))
		else $error("cell beat from a clear bit");

	// the scan never walks past the used bits
	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_step |-> (pos_q < nbits))
		else $error("scan past used bits");

	// an empty run is one beat with no cell, marked last
	a_empty_beat: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.empty_load |=> (result_valid && last && !has_cell))
		else $error("empty run beat malformed");

	// a beat is only loaded into a free result register
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_load || cmd.empty_load) |-> (!out_valid_q || !result_stall))
		else $error("result register overwritten");

endmodule

>>> tb/tb_spiral_bit_pattern_placer_unit.sv
// tb_spiral_bit_pattern_placer_unit: self-checking testbench for the spiral bit pattern placer.
// A directed table, then random phases across register settings, each checked against a
// spiral placement predictor. Depends on sbpp_pkg and spiral_bit_pattern_placer_unit.
`timescale 1ns / 1ps

module tb_spiral_bit_pattern_placer_unit
	import sbpp_pkg::*;
();

	localparam int          WALK_LEN        = 64;
	localparam int          DRAIN_CYCLES    = 2 * WALK_LEN + 16;
	localparam int          IDLE_LIMIT      = 2000;
	localparam int          ITEMS_PER_PHASE = 14;
	localparam int          NUM_PHASES      = 9;
	localparam int          NO_IDLE_PHASE   = 6;
	localparam logic [1:0]  CMD_UNUSED      = 2'd3;

	// one result beat as the block presents it
	typedef struct packed {
		logic [5:0]        grid_width;
		logic [5:0]        grid_height;
		logic signed [5:0] origin_x;
		logic signed [5:0] origin_y;
		logic              has_cell;
		logic [4:0]        cell_col;
		logic [4:0]        cell_row;
		logic              last;
	} cell_result_t;

	// directed row: typed rows carry the single result they must give
	typedef struct packed {
		logic [1:0]   cmd;
		logic [63:0]  value;
		logic         typed;
		cell_result_t lit;
	} stim_row_t;

	// empty pattern and lone origin cell under reset settings (64 bits, pad 0)
	localparam cell_result_t LIT_EMPTY  = '{6'd1, 6'd1, 6'sd0, 6'sd0, 1'b0, 5'd0, 5'd0, 1'b1};
	localparam cell_result_t LIT_ORIGIN = '{6'd1, 6'd1, 6'sd0, 6'sd0, 1'b1, 5'd0, 5'd0, 1'b1};
	localparam cell_result_t NO_LIT     = '0;

	localparam int NUM_DIRECTED = 19;
	localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
		'{CMD_GEN_INDEX,    64'd0,                  1'b1, LIT_EMPTY},
		'{CMD_GEN_INDEX,    64'd1,                  1'b1, LIT_ORIGIN},
		'{CMD_GEN_INDEX,    64'hFFFF_FFFF_FFFF_FFFF, 1'b0, NO_LIT},
		'{CMD_GEN_INDEX,    64'h8000_0000_0000_0000, 1'b0, NO_LIT},
		'{CMD_GEN_INDEX,    64'hAAAA_AAAA_AAAA_AAAA, 1'b0, NO_LIT},
		'{CMD_GEN_INDEX,    64'h5555_5555_5555_5555, 1'b0, NO_LIT},
		'{CMD_GEN_INDEX,    64'd2,                  1'b0, NO_LIT},
		'{CMD_GEN_COUNTER,  64'd0,                  1'b1, LIT_EMPTY},
		'{CMD_GEN_COUNTER,  64'd0,                  1'b1, LIT_ORIGIN},
		'{CMD_UNUSED,       64'hFFFF_FFFF_FFFF_FFFF, 1'b0, NO_LIT},
		'{CMD_LOAD_COUNTER, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, NO_LIT},
		'{CMD_GEN_COUNTER,  64'd0,                  1'b0, NO_LIT},
		'{CMD_GEN_COUNTER,  64'd0,                  1'b1, LIT_EMPTY},
		'{CMD_LOAD_COUNTER, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0, NO_LIT},
		'{CMD_GEN_COUNTER,  64'd0,                  1'b0, NO_LIT},
		'{CMD_GEN_COUNTER,  64'd0,                  1'b0, NO_LIT},
		'{CMD_GEN_COUNTER,  64'd0,                  1'b1, LIT_EMPTY},
		'{CMD_GEN_INDEX,    64'h8000_0000_0000_0001, 1'b0, NO_LIT},
		'{CMD_LOAD_COUNTER, 64'd1,                  1'b0, NO_LIT}
	};

	// register settings per phase: zero bits, too many bits, pad data with high bits set
	localparam logic [6:0] PHASE_BITS [NUM_PHASES] = '{
		7'd64, 7'd0, 7'd127, 7'd1, 7'd5, 7'd65, 7'd12, 7'd33, 7'd64
	};
	localparam logic [6:0] PHASE_PAD [NUM_PHASES] = '{
		7'd0, 7'd5, 7'h7F, 7'd15, 7'd3, 7'd0, 7'd9, 7'h71, 7'd15
	};

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              item_valid   = 1'b0;
	logic              item_stall;
	logic [1:0]        command      = '0;
	logic [63:0]       index_value  = '0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	logic [5:0]        grid_width;
	logic [5:0]        grid_height;
	logic signed [5:0] origin_x;
	logic signed [5:0] origin_y;
	logic              has_cell;
	logic [4:0]        cell_col;
	logic [4:0]        cell_row;
	logic              last;
	logic              cfg_valid    = 1'b0;
	logic              cfg_ready;
	logic [1:0]        cfg_index    = '0;
	logic [6:0]        cfg_data     = '0;

	// predictor state
	logic [6:0]   bits_sel    = 7'd64;
	logic [3:0]   pad_sel     = 4'd0;
	logic [63:0]  seq_counter = '0;
	int           walk_x [WALK_LEN];
	int           walk_y [WALK_LEN];
	cell_result_t expected_cells [$];

	bit           no_idle     = 1'b0;
	int           mismatches  = 0;
	int           idle_cycles = 0;
	cell_result_t seen_cell;
	cell_result_t want_cell;

	spiral_bit_pattern_placer_unit u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.command     (command),
		.index_value (index_value),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.grid_width  (grid_width),
		.grid_height (grid_height),
		.origin_x    (origin_x),
		.origin_y    (origin_y),
		.has_cell    (has_cell),
		.cell_col    (cell_col),
		.cell_row    (cell_row),
		.last        (last),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// walk right, up, left, down with run lengths 1,1,2,2,3,3,...
	function automatic void build_walk();
		int px;
		int py;
		int dir;
		int run;
		int run_left;
		px = 0;
		py = 0;
		dir = 0;
		run = 0;
		run_left = 1;
		for (int k = 0; k < WALK_LEN; k++) begin
			walk_x[k] = px;
			walk_y[k] = py;
			case (dir)
				0: px = px + 1;
				1: py = py + 1;
				2: px = px - 1;
				default: py = py - 1;
			endcase
			run_left = run_left - 1;
			if (run_left == 0) begin
				dir = (dir + 1) % 4;
				run = run + 1;
				run_left = run / 2 + 1;
			end
		end
	endfunction

	function automatic int used_bits();
		return (bits_sel > 7'd64) ? 64 : int'(bits_sel);
	endfunction

	function automatic logic [63:0] bits_mask();
		if (used_bits() == 64)
			return '1;
		return (64'd1 << used_bits()) - 64'd1;
	endfunction

	// box of the live cells, then one beat per live cell in bit order
	function automatic void place_pattern(input logic [63:0] pattern);
		int           nb;
		int           pd;
		int           minx;
		int           maxx;
		int           miny;
		int           maxy;
		int           top;
		bit           any;
		logic [63:0]  live;
		cell_result_t r;
		nb = used_bits();
		pd = int'(pad_sel);
		live = pattern & bits_mask();
		any = 1'b0;
		minx = 0;
		maxx = 0;
		miny = 0;
		maxy = 0;
		top = 0;
		for (int k = 0; k < nb; k++) begin
			if (live[k]) begin
				if (!any || walk_x[k] < minx) minx = walk_x[k];
				if (!any || walk_x[k] > maxx) maxx = walk_x[k];
				if (!any || walk_y[k] < miny) miny = walk_y[k];
				if (!any || walk_y[k] > maxy) maxy = walk_y[k];
				any = 1'b1;
				top = k;
			end
		end
		// empty pattern: one square beat of side 1 + 2*pad
		if (!any) begin
			r = '{6'(1 + 2 * pd), 6'(1 + 2 * pd), 6'(-pd), 6'(-pd), 1'b0, 5'd0, 5'd0, 1'b1};
			expected_cells.push_back(r);
			return;
		end
		for (int k = 0; k < nb; k++) begin
			if (live[k]) begin
				r.grid_width  = 6'(maxx - minx + 1 + 2 * pd);
				r.grid_height = 6'(maxy - miny + 1 + 2 * pd);
				r.origin_x    = 6'(minx - pd);
				r.origin_y    = 6'(miny - pd);
				r.has_cell    = 1'b1;
				r.cell_col    = 5'(walk_x[k] - minx + pd);
				r.cell_row    = 5'(walk_y[k] - miny + pd);
				r.last        = (k == top);
				expected_cells.push_back(r);
			end
		end
	endfunction

	function automatic void predict_item(input logic [1:0] cmd, input logic [63:0] val);
		case (cmd)
			CMD_GEN_INDEX: place_pattern(val);
			CMD_GEN_COUNTER: begin
				place_pattern(seq_counter);
				seq_counter = (seq_counter + 64'd1) & bits_mask();
			end
			CMD_LOAD_COUNTER: seq_counter = val & bits_mask();
			default: ;
		endcase
	endfunction

	function automatic string show_cell(input cell_result_t c);
		return $sformatf("w=%0d h=%0d ox=%0d oy=%0d has=%0b col=%0d row=%0d last=%0b",
			c.grid_width, c.grid_height, c.origin_x, c.origin_y, c.has_cell,
			c.cell_col, c.cell_row, c.last);
	endfunction

	function automatic void log_mismatch(input string what, input cell_result_t want,
			input cell_result_t got);
		mismatches = mismatches + 1;
		if (mismatches <= 10)
			$display("%0t %s: expected [%s] got [%s]", $realtime, what, show_cell(want),
				show_cell(got));
	endfunction

	// one item beat; typed rows replace the predicted beats with the given one
	task automatic send_item(input logic [1:0] cmd, input logic [63:0] val, input logic typed,
			input cell_result_t lit);
		int n;
		if (!no_idle) begin
			while ($urandom_range(0, 99) < 35) begin
				item_valid <= 1'b0;
				@(posedge clk);
			end
		end
		item_valid  <= 1'b1;
		command     <= cmd;
		index_value <= val;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		n = expected_cells.size();
		predict_item(cmd, val);
		if (typed) begin
			while (expected_cells.size() > n)
				void'(expected_cells.pop_back());
			expected_cells.push_back(lit);
		end
	endtask

	// both registers in back-to-back beats
	task automatic set_config(input logic [6:0] bits_data, input logic [6:0] pad_data);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_BITS_IN_USE;
		cfg_data  <= bits_data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		bits_sel  = bits_data;
		cfg_index <= CFG_PAD;
		cfg_data  <= pad_data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		pad_sel   = pad_data[3:0];
		cfg_valid <= 1'b0;
	endtask

	// all beats in, then let a trailing load or unused item finish
	task automatic wait_drained();
		while (expected_cells.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// zero, ones, full random, a few set bits, small values, or a few clear bits
	function automatic logic [63:0] random_pattern();
		logic [63:0] v;
		int          hi;
		int          mode;
		hi = (used_bits() == 0) ? 63 : used_bits() - 1;
		mode = $urandom_range(0, 9);
		v = '0;
		case (mode)
			0: v = '0;
			1: v = '1;
			2, 3, 4: v = {$urandom, $urandom};
			8: v = 64'($urandom_range(0, 31));
			default: begin
				repeat ($urandom_range(1, 3)) v[$urandom_range(0, hi)] = 1'b1;
				if (mode == 9)
					v = ~v;
			end
		endcase
		return v;
	endfunction

	// receiver stalls at random, except in the no-idle phase
	always @(posedge clk)
		result_stall <= !no_idle && ($urandom_range(0, 99) < 35);

	// result checker
	always @(posedge clk) begin
		if (result_valid && !result_stall) begin
			seen_cell = '{grid_width, grid_height, origin_x, origin_y, has_cell, cell_col,
				cell_row, last};
			if (expected_cells.size() == 0) begin
				log_mismatch("result beat with nothing expected", NO_LIT, seen_cell);
			end else begin
				want_cell = expected_cells.pop_front();
				if (seen_cell.grid_width !== want_cell.grid_width ||
						seen_cell.grid_height !== want_cell.grid_height ||
						seen_cell.origin_x !== want_cell.origin_x ||
						seen_cell.origin_y !== want_cell.origin_y ||
						seen_cell.has_cell !== want_cell.has_cell ||
						seen_cell.cell_col !== want_cell.cell_col ||
						seen_cell.cell_row !== want_cell.cell_row ||
						seen_cell.last !== want_cell.last)
					log_mismatch("result beat mismatch", want_cell, seen_cell);
			end
		end
	end

	// watchdog on cycles with no beat on any channel
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int          counted;
		int          roll;
		logic [1:0]  op;
		logic [63:0] val;
		build_walk();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed table under reset settings
		for (int i = 0; i < NUM_DIRECTED; i++)
			send_item(DIRECTED[i].cmd, DIRECTED[i].value, DIRECTED[i].typed, DIRECTED[i].lit);
		item_valid <= 1'b0;

		// random phases, each under its own register settings
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			wait_drained();
			set_config(PHASE_BITS[ph], PHASE_PAD[ph]);
			no_idle = (ph == NO_IDLE_PHASE);
			counted = 0;
			while (counted < ITEMS_PER_PHASE) begin
				roll = $urandom_range(0, 99);
				if (roll < 8)
					op = CMD_UNUSED;
				else if (roll < 50)
					op = CMD_GEN_INDEX;
				else if (roll < 80)
					op = CMD_GEN_COUNTER;
				else
					op = CMD_LOAD_COUNTER;
				val = random_pattern();
				send_item(op, val, 1'b0, NO_LIT);
				if (op != CMD_UNUSED)
					counted = counted + 1;
			end
			item_valid <= 1'b0;
		end
		no_idle = 1'b0;

		wait_drained();
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
